// ===== src/vps_pkg.sv =====
// ----------------------------------------------------------------------------
// vps_pkg: shared types and constants of the Verlet particle step
// Field widths, register indexes, reset values and the saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package vps_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned LenW  = 31;
  localparam int unsigned RestW = 17;
  localparam int unsigned DampW = 17;
  localparam int unsigned StepW = 32;
  localparam int unsigned AddrW = 2;

  localparam int unsigned FactorFracBits = 16;
  localparam int unsigned PosFracBitsDef = 16;

  localparam int unsigned VelW = PosW + 1;
  localparam int unsigned SatW = 40;

  localparam logic [StepW-1:0] StepSqReset  = 32'd274878;
  localparam logic [DampW-1:0] DampReset    = 17'd65470;
  localparam int unsigned      ArenaWUnits  = 800;
  localparam int unsigned      ArenaHUnits  = 600;

  localparam logic [AddrW-1:0] RegStepSq   = 2'd0;
  localparam logic [AddrW-1:0] RegDamping  = 2'd1;
  localparam logic [AddrW-1:0] RegArenaW   = 2'd2;
  localparam logic [AddrW-1:0] RegArenaH   = 2'd3;

  localparam logic signed [SatW-1:0] PosMaxW = SatW'(64'sh7FFF_FFFF);
  localparam logic signed [SatW-1:0] PosMinW = -PosMaxW - SatW'(64'sd1);

  typedef logic signed [PosW-1:0] pos_t;

  typedef struct packed {
    logic [LenW-1:0]  radius;
    logic [RestW-1:0] restitution;
    logic             last;
  } side_t;

  function automatic pos_t sat_pos(input logic signed [SatW-1:0] x);
    pos_t res;
    if (x > PosMaxW) begin
      res = PosMaxW[PosW-1:0];
    end else if (x < PosMinW) begin
      res = PosMinW[PosW-1:0];
    end else begin
      res = x[PosW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/vps_advance.sv =====
// ----------------------------------------------------------------------------
// vps_advance: damped position-Verlet update, three register stages
// Velocity, then damping and acceleration products, then sum and saturate, or keep if not free.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_advance (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  vps_pkg::pos_t                pos_i  [2],
  input  vps_pkg::pos_t                prev_i [2],
  input  vps_pkg::pos_t                acc_i  [2],
  input  logic                         free_i,
  input  vps_pkg::side_t               side_i,
  input  logic [vps_pkg::DampW-1:0]    damp_i,
  input  logic [vps_pkg::StepW-1:0]    step_sq_i,
  output logic                         valid_o,
  output vps_pkg::pos_t                pos_o  [2],
  output vps_pkg::pos_t                prev_o [2],
  output vps_pkg::side_t               side_o
);
  import vps_pkg::*;

  localparam int unsigned DProdW = VelW + DampW + 1;
  localparam int unsigned DvW    = DProdW - FactorFracBits;
  localparam int unsigned AProdW = PosW + StepW + 1;
  localparam int unsigned DaW    = AProdW - StepW;

  logic                     valid1_q, valid2_q, valid3_q;
  pos_t                     pos1_q [2];
  logic signed [VelW-1:0]   vel1_q [2];
  pos_t                     acc1_q [2];
  logic                     free1_q;
  side_t                    side1_q;

  logic signed [DProdW-1:0] dprod [2];
  logic signed [AProdW-1:0] aprod [2];
  logic signed [DvW-1:0]    dv2_q [2];
  logic signed [DaW-1:0]    da2_q [2];
  pos_t                     pos2_q [2];
  logic                     free2_q;
  side_t                    side2_q;

  logic signed [SatW-1:0]   sum [2];
  pos_t                     pos3_d [2];
  pos_t                     pos3_q [2];
  pos_t                     prev3_q [2];
  side_t                    side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dprod[a] = $signed({1'b0, damp_i}) * vel1_q[a];
      aprod[a] = acc1_q[a] * $signed({1'b0, step_sq_i});
      sum[a]   = SatW'(pos2_q[a]) + SatW'(dv2_q[a]) + SatW'(da2_q[a]);
      pos3_d[a] = free2_q ? sat_pos(sum[a]) : pos2_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      pos1_q[a]  <= pos_i[a];
      vel1_q[a]  <= VelW'(pos_i[a]) - VelW'(prev_i[a]);
      acc1_q[a]  <= acc_i[a];
      dv2_q[a]   <= dprod[a][DProdW-1:FactorFracBits];
      da2_q[a]   <= aprod[a][AProdW-1:StepW];
      pos2_q[a]  <= pos1_q[a];
      pos3_q[a]  <= pos3_d[a];
      prev3_q[a] <= pos2_q[a];
    end
    free1_q <= free_i;
    side1_q <= side_i;
    free2_q <= free1_q;
    side2_q <= side1_q;
    side3_q <= side2_q;
  end

  assign valid_o = valid3_q;
  assign pos_o   = pos3_q;
  assign prev_o  = prev3_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

// ===== src/vps_wall.sv =====
// ----------------------------------------------------------------------------
// vps_wall: clamp to one wall pair (x and y), three register stages
// Hit test, then restitution product, then clamp and reflect or keep.
// ----------------------------------------------------------------------------
`default_nettype none

module vps_wall #(
  parameter bit NearWall = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  vps_pkg::pos_t              pos_i   [2],
  input  vps_pkg::pos_t              prev_i  [2],
  input  logic [vps_pkg::LenW-1:0]   limit_i [2],
  input  vps_pkg::side_t             side_i,
  output logic                       valid_o,
  output vps_pkg::pos_t              pos_o   [2],
  output vps_pkg::pos_t              prev_o  [2],
  output vps_pkg::side_t             side_o
);
  import vps_pkg::*;

  localparam int unsigned RProdW = VelW + RestW + 1;
  localparam int unsigned RvW    = RProdW - FactorFracBits;

  logic signed [PosW-1:0]   rad_s;
  logic signed [PosW-1:0]   lim_s [2];
  logic signed [SatW-1:0]   at_w  [2];
  logic                     hit_d [2];

  logic                     valid1_q, valid2_q, valid3_q;
  logic                     hit1_q [2];
  pos_t                     at1_q  [2];
  logic signed [VelW-1:0]   vel1_q [2];
  pos_t                     pos1_q [2];
  pos_t                     prev1_q [2];
  side_t                    side1_q;

  logic signed [RProdW-1:0] rprod [2];
  logic                     hit2_q  [2];
  logic                     into2_q [2];
  pos_t                     at2_q   [2];
  logic signed [VelW-1:0]   vel2_q  [2];
  logic signed [RvW-1:0]    rv2_q   [2];
  pos_t                     pos2_q  [2];
  pos_t                     prev2_q [2];
  side_t                    side2_q;

  pos_t                     pos3_d  [2];
  pos_t                     prev3_d [2];
  pos_t                     pos3_q  [2];
  pos_t                     prev3_q [2];
  side_t                    side3_q;

  assign rad_s = $signed({1'b0, side_i.radius});

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      lim_s[a] = $signed({1'b0, limit_i[a]});
      if (NearWall) begin
        at_w[a]  = SatW'(lim_s[a]) + SatW'(rad_s);
        hit_d[a] = (SatW'(pos_i[a]) - SatW'(rad_s)) < SatW'(lim_s[a]);
      end else begin
        at_w[a]  = SatW'(lim_s[a]) - SatW'(rad_s);
        hit_d[a] = (SatW'(pos_i[a]) + SatW'(rad_s)) > SatW'(lim_s[a]);
      end
      rprod[a] = vel1_q[a] * $signed({1'b0, side1_q.restitution});
      pos3_d[a]  = pos2_q[a];
      prev3_d[a] = prev2_q[a];
      if (hit2_q[a]) begin
        pos3_d[a] = at2_q[a];
        if (into2_q[a]) begin
          prev3_d[a] = sat_pos(SatW'(at2_q[a]) + SatW'(rv2_q[a]));
        end else begin
          prev3_d[a] = sat_pos(SatW'(at2_q[a]) - SatW'(vel2_q[a]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      hit1_q[a]  <= hit_d[a];
      at1_q[a]   <= sat_pos(at_w[a]);
      vel1_q[a]  <= VelW'(pos_i[a]) - VelW'(prev_i[a]);
      pos1_q[a]  <= pos_i[a];
      prev1_q[a] <= prev_i[a];
      hit2_q[a]  <= hit1_q[a];
      into2_q[a] <= NearWall ? (vel1_q[a] < 0) : (vel1_q[a] > 0);
      at2_q[a]   <= at1_q[a];
      vel2_q[a]  <= vel1_q[a];
      rv2_q[a]   <= rprod[a][RProdW-1:FactorFracBits];
      pos2_q[a]  <= pos1_q[a];
      prev2_q[a] <= prev1_q[a];
      pos3_q[a]  <= pos3_d[a];
      prev3_q[a] <= prev3_d[a];
    end
    side1_q <= side_i;
    side2_q <= side1_q;
    side3_q <= side2_q;
  end

  assign valid_o = valid3_q;
  assign pos_o   = pos3_q;
  assign prev_o  = prev3_q;
  assign side_o  = side3_q;

endmodule

`default_nettype wire

// ===== src/verlet_particle_step.sv =====
// ----------------------------------------------------------------------------
// verlet_particle_step: one position-Verlet step with wall collisions
// Streams particle records in and advanced, wall-clamped records out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the particle fields and raise start; an item is taken at
//   every rising edge with start high and busy low. busy stays low, so one
//   item can enter on every cycle.
//   Output: done_o is high for one cycle with the advanced record on the
//   new_* ports and last_out_o; the receiver takes it in that cycle.
//   Pipeline: three stages of Verlet update (difference, products, sum),
//   then three for the left/top walls and three for the right/bottom
//   walls (hit test, restitution product, clamp).
//   Throughput: one item per cycle, set by the fully pipelined multipliers.
//   Configuration: write registers through cfg_we_i, cfg_addr_i and
//   cfg_wdata_i while no item is in flight; a write takes effect at once.
//   Reset: in-flight items are dropped and registers return to the defaults
//   (step 0.008 squared, damping 0.999, arena 800 by 600).
//   The receiver cannot stall, so no back-pressure exists.
// ----------------------------------------------------------------------------
`default_nettype none

module verlet_particle_step #(
  parameter int unsigned PosFracBits = vps_pkg::PosFracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we_i,
  input  logic [vps_pkg::AddrW-1:0]    cfg_addr_i,
  input  logic [vps_pkg::StepW-1:0]    cfg_wdata_i,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           prev_x_i,
  input  logic signed [31:0]           prev_y_i,
  input  logic signed [31:0]           acc_x_i,
  input  logic signed [31:0]           acc_y_i,
  input  logic [vps_pkg::LenW-1:0]     radius_i,
  input  logic [vps_pkg::RestW-1:0]    restitution_i,
  input  logic                         is_free_i,
  input  logic                         last_particle_i,
  output logic                         done_o,
  output logic signed [31:0]           new_pos_x_o,
  output logic signed [31:0]           new_pos_y_o,
  output logic signed [31:0]           new_prev_x_o,
  output logic signed [31:0]           new_prev_y_o,
  output logic                         last_out_o
);
  import vps_pkg::*;

  localparam logic [63:0] ArenaWRst64 = 64'(ArenaWUnits) << PosFracBits;
  localparam logic [63:0] ArenaHRst64 = 64'(ArenaHUnits) << PosFracBits;
  localparam logic [LenW-1:0] ArenaWReset = ArenaWRst64[LenW-1:0];
  localparam logic [LenW-1:0] ArenaHReset = ArenaHRst64[LenW-1:0];

  logic [StepW-1:0] step_sq_q;
  logic [DampW-1:0] damp_q;
  logic [LenW-1:0]  arena_w_q;
  logic [LenW-1:0]  arena_h_q;

  pos_t             pos_in  [2];
  pos_t             prev_in [2];
  pos_t             acc_in  [2];
  side_t            side_in;
  logic             accept;

  logic             adv_valid;
  pos_t             adv_pos  [2];
  pos_t             adv_prev [2];
  side_t            adv_side;

  logic             near_valid;
  pos_t             near_pos  [2];
  pos_t             near_prev [2];
  side_t            near_side;
  logic [LenW-1:0]  near_lim  [2];
  logic [LenW-1:0]  far_lim   [2];

  logic             far_valid;
  pos_t             far_pos  [2];
  pos_t             far_prev [2];
  side_t            far_side;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_sq_q <= StepSqReset;
      damp_q    <= DampReset;
      arena_w_q <= ArenaWReset;
      arena_h_q <= ArenaHReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegStepSq:  step_sq_q <= cfg_wdata_i;
        RegDamping: damp_q    <= cfg_wdata_i[DampW-1:0];
        RegArenaW:  arena_w_q <= cfg_wdata_i[LenW-1:0];
        RegArenaH:  arena_h_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_in[0]  = pos_x_i;
  assign pos_in[1]  = pos_y_i;
  assign prev_in[0] = prev_x_i;
  assign prev_in[1] = prev_y_i;
  assign acc_in[0]  = acc_x_i;
  assign acc_in[1]  = acc_y_i;

  assign side_in.radius      = radius_i;
  assign side_in.restitution = restitution_i;
  assign side_in.last        = last_particle_i;

  assign near_lim[0] = '0;
  assign near_lim[1] = '0;
  assign far_lim[0]  = arena_w_q;
  assign far_lim[1]  = arena_h_q;

  vps_advance u_advance (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .pos_i     (pos_in),
    .prev_i    (prev_in),
    .acc_i     (acc_in),
    .free_i    (is_free_i),
    .side_i    (side_in),
    .damp_i    (damp_q),
    .step_sq_i (step_sq_q),
    .valid_o   (adv_valid),
    .pos_o     (adv_pos),
    .prev_o    (adv_prev),
    .side_o    (adv_side)
  );

  vps_wall #(
    .NearWall (1'b1)
  ) u_wall_near (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (adv_valid),
    .pos_i   (adv_pos),
    .prev_i  (adv_prev),
    .limit_i (near_lim),
    .side_i  (adv_side),
    .valid_o (near_valid),
    .pos_o   (near_pos),
    .prev_o  (near_prev),
    .side_o  (near_side)
  );

  vps_wall #(
    .NearWall (1'b0)
  ) u_wall_far (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (near_valid),
    .pos_i   (near_pos),
    .prev_i  (near_prev),
    .limit_i (far_lim),
    .side_i  (near_side),
    .valid_o (far_valid),
    .pos_o   (far_pos),
    .prev_o  (far_prev),
    .side_o  (far_side)
  );

  assign done_o       = far_valid;
  assign new_pos_x_o  = far_pos[0];
  assign new_pos_y_o  = far_pos[1];
  assign new_prev_x_o = far_prev[0];
  assign new_prev_y_o = far_prev[1];
  assign last_out_o   = far_side.last;

endmodule

`default_nettype wire

// ===== sim/verlet_particle_step_tb.sv =====
// ----------------------------------------------------------------------------
// verlet_particle_step_tb: self-checking bench for the Verlet particle step
// Drives particle records through the command port and predicts each
// advanced record in a scoreboard: damped Verlet update, truncated products,
// saturation and the four wall clamps in order. Runs a directed set at the
// reset settings, then random records over several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
  vps_pkg::pos_t                 pos_x;
  vps_pkg::pos_t                 pos_y;
  vps_pkg::pos_t                 prev_x;
  vps_pkg::pos_t                 prev_y;
  vps_pkg::pos_t                 acc_x;
  vps_pkg::pos_t                 acc_y;
  logic [vps_pkg::LenW-1:0]      radius;
  logic [vps_pkg::RestW-1:0]     restitution;
  logic                          is_free;
  logic                          last;
} particle_in_t;

typedef struct packed {
  vps_pkg::pos_t new_pos_x;
  vps_pkg::pos_t new_pos_y;
  vps_pkg::pos_t new_prev_x;
  vps_pkg::pos_t new_prev_y;
  logic          last;
} particle_out_t;

class particle_scoreboard;
  logic [vps_pkg::StepW-1:0] step_sq;
  logic [vps_pkg::DampW-1:0] damping;
  logic [vps_pkg::LenW-1:0]  arena_w;
  logic [vps_pkg::LenW-1:0]  arena_h;
  particle_out_t             pending_records[$];
  int unsigned               mismatches;

  function new();
    step_sq    = vps_pkg::StepSqReset;
    damping    = vps_pkg::DampReset;
    arena_w    = vps_pkg::LenW'(vps_pkg::ArenaWUnits << vps_pkg::PosFracBitsDef);
    arena_h    = vps_pkg::LenW'(vps_pkg::ArenaHUnits << vps_pkg::PosFracBitsDef);
    mismatches = 0;
  endfunction

  function void write_reg(input logic [vps_pkg::AddrW-1:0] idx, input logic [31:0] data);
    case (idx)
      vps_pkg::RegStepSq:  step_sq = data;
      vps_pkg::RegDamping: damping = data[vps_pkg::DampW-1:0];
      vps_pkg::RegArenaW:  arena_w = data[vps_pkg::LenW-1:0];
      vps_pkg::RegArenaH:  arena_h = data[vps_pkg::LenW-1:0];
      default: ;
    endcase
  endfunction

  function longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void move_axis(input longint p, input longint prev, input longint acc,
                          input bit free, output longint np, output longint nprev);
    longint dmp, stp, v, dv, da;
    dmp = damping;
    stp = step_sq;
    v   = p - prev;
    dv  = (dmp * v) >>> 16;
    da  = (acc * stp) >>> 32;
    np    = free ? sat32(p + dv + da) : p;
    nprev = p;
  endfunction

  function void bounce(inout longint p, inout longint prev, input longint at,
                       input int into, input longint rest);
    longint v;
    v = p - prev;
    p = sat32(at);
    if ((into < 0 && v < 0) || (into > 0 && v > 0)) begin
      prev = sat32(p + ((v * rest) >>> 16));
    end else begin
      prev = sat32(p - v);
    end
  endfunction

  function void clamp_walls(inout longint p, inout longint prev, input longint r,
                            input longint far, input longint rest);
    if (p - r < 0) bounce(p, prev, r, -1, rest);
    if (p + r > far) bounce(p, prev, far - r, 1, rest);
  endfunction

  function void note_item(input particle_in_t it);
    longint nx, ny, nqx, nqy, r, rest, w, h;
    particle_out_t res;
    r    = it.radius;
    rest = it.restitution;
    w    = arena_w;
    h    = arena_h;
    move_axis(it.pos_x, it.prev_x, it.acc_x, it.is_free, nx, nqx);
    move_axis(it.pos_y, it.prev_y, it.acc_y, it.is_free, ny, nqy);
    clamp_walls(nx, nqx, r, w, rest);
    clamp_walls(ny, nqy, r, h, rest);
    res.new_pos_x  = nx[31:0];
    res.new_pos_y  = ny[31:0];
    res.new_prev_x = nqx[31:0];
    res.new_prev_y = nqy[31:0];
    res.last       = it.last;
    pending_records.push_back(res);
  endfunction

  function void compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(input particle_out_t got);
    particle_out_t want;
    if (pending_records.size() == 0) begin
      $error("unexpected result: new_pos_x %0d new_pos_y %0d", got.new_pos_x, got.new_pos_y);
      mismatches++;
      return;
    end
    want = pending_records.pop_front();
    compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
    compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
    compare_field("new_prev_x", want.new_prev_x, got.new_prev_x);
    compare_field("new_prev_y", want.new_prev_y, got.new_prev_y);
    compare_field("last_out", want.last, got.last);
  endfunction
endclass

module verlet_particle_step_tb;
  import vps_pkg::*;

  localparam int unsigned PipeDepth  = 9;
  localparam int unsigned CycleLimit = 200000;
  localparam longint      One        = 64'sd65536;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic                cfg_we_i        = 1'b0;
  logic [AddrW-1:0]    cfg_addr_i      = '0;
  logic [StepW-1:0]    cfg_wdata_i     = '0;
  pos_t                pos_x_i         = '0;
  pos_t                pos_y_i         = '0;
  pos_t                prev_x_i        = '0;
  pos_t                prev_y_i        = '0;
  pos_t                acc_x_i         = '0;
  pos_t                acc_y_i         = '0;
  logic [LenW-1:0]     radius_i        = '0;
  logic [RestW-1:0]    restitution_i   = '0;
  logic                is_free_i       = 1'b0;
  logic                last_particle_i = 1'b0;
  logic                done_o;
  pos_t                new_pos_x_o;
  pos_t                new_pos_y_o;
  pos_t                new_prev_x_o;
  pos_t                new_prev_y_o;
  logic                last_out_o;

  particle_scoreboard  sb;
  int unsigned         cycle_count = 0;

  verlet_particle_step dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .prev_x_i        (prev_x_i),
    .prev_y_i        (prev_y_i),
    .acc_x_i         (acc_x_i),
    .acc_y_i         (acc_y_i),
    .radius_i        (radius_i),
    .restitution_i   (restitution_i),
    .is_free_i       (is_free_i),
    .last_particle_i (last_particle_i),
    .done_o          (done_o),
    .new_pos_x_o     (new_pos_x_o),
    .new_pos_y_o     (new_pos_y_o),
    .new_prev_x_o    (new_prev_x_o),
    .new_prev_y_o    (new_prev_y_o),
    .last_out_o      (last_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(particle_out_t'{new_pos_x_o, new_pos_y_o, new_prev_x_o, new_prev_y_o,
                                      last_out_o});
    end
  end

  function automatic particle_in_t particle(input longint px, input longint py,
                                            input longint qx, input longint qy,
                                            input longint ax, input longint ay,
                                            input longint r, input longint rest,
                                            input bit free, input bit last);
    particle_in_t it;
    it.pos_x       = px[31:0];
    it.pos_y       = py[31:0];
    it.prev_x      = qx[31:0];
    it.prev_y      = qy[31:0];
    it.acc_x       = ax[31:0];
    it.acc_y       = ay[31:0];
    it.radius      = r[LenW-1:0];
    it.restitution = rest[RestW-1:0];
    it.is_free     = free;
    it.last        = last;
    return it;
  endfunction

  function automatic longint spread(input int unsigned bits);
    return longint'($urandom_range(0, 2 << bits)) - (longint'(1) << bits);
  endfunction

  function automatic longint corner_value(input longint far);
    case ($urandom_range(0, 6))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return 0;
      3: return -1;
      4: return 1;
      5: return far;
      default: return -far;
    endcase
  endfunction

  function automatic void random_axis(input longint far, input longint r,
                                      output pos_t p, output pos_t prev, output pos_t acc);
    longint base, v;
    case ($urandom_range(0, 2))
      0: base = r + spread($urandom_range(0, 20));
      1: base = far - r + spread($urandom_range(0, 20));
      default: base = (far == 0) ? 0 : longint'($urandom) % (far + 1);
    endcase
    v    = spread($urandom_range(0, 22));
    p    = base[31:0];
    prev = pos_t'(base - v);
    acc  = pos_t'(spread($urandom_range(0, 26)));
  endfunction

  function automatic particle_in_t random_particle();
    particle_in_t it;
    int unsigned  mode;
    longint       r;
    mode           = $urandom_range(0, 9);
    it.is_free     = ($urandom_range(0, 4) != 0);
    it.last        = ($urandom_range(0, 1) != 0);
    it.restitution = RestW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                        : $urandom_range(0, 65536));
    if (mode < 2) begin
      it.pos_x       = $urandom;
      it.pos_y       = $urandom;
      it.prev_x      = $urandom;
      it.prev_y      = $urandom;
      it.acc_x       = $urandom;
      it.acc_y       = $urandom;
      it.radius      = LenW'($urandom);
      it.restitution = RestW'($urandom);
      it.is_free     = ($urandom_range(0, 1) != 0);
    end else if (mode == 2) begin
      it.pos_x  = pos_t'(corner_value(sb.arena_w));
      it.prev_x = pos_t'(corner_value(sb.arena_w));
      it.acc_x  = pos_t'(corner_value(sb.arena_w));
      it.pos_y  = pos_t'(corner_value(sb.arena_h));
      it.prev_y = pos_t'(corner_value(sb.arena_h));
      it.acc_y  = pos_t'(corner_value(sb.arena_h));
      case ($urandom_range(0, 3))
        0: it.radius = '0;
        1: it.radius = '1;
        2: it.radius = sb.arena_w >> 1;
        default: it.radius = LenW'($urandom_range(0, 1 << 20));
      endcase
    end else begin
      r         = $urandom_range(0, 1 << $urandom_range(0, 22));
      it.radius = r[LenW-1:0];
      random_axis(sb.arena_w, r, it.pos_x, it.prev_x, it.acc_x);
      random_axis(sb.arena_h, r, it.pos_y, it.prev_y, it.acc_y);
    end
    return it;
  endfunction

  task automatic send_item(input particle_in_t it);
    start           <= 1'b1;
    pos_x_i         <= it.pos_x;
    pos_y_i         <= it.pos_y;
    prev_x_i        <= it.prev_x;
    prev_y_i        <= it.prev_y;
    acc_x_i         <= it.acc_x;
    acc_y_i         <= it.acc_y;
    radius_i        <= it.radius;
    restitution_i   <= it.restitution;
    is_free_i       <= it.is_free;
    last_particle_i <= it.last;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  task automatic pause(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold off until every record is back, then let the pipeline settle
  task automatic drain_pipeline();
    start <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] step_sq, input logic [31:0] damp,
                            input logic [31:0] arena_w, input logic [31:0] arena_h);
    logic [AddrW-1:0] idx[4];
    logic [31:0]      val[4];
    idx = '{RegStepSq, RegDamping, RegArenaW, RegArenaH};
    val = '{step_sq, damp, arena_w, arena_h};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx[k];
      cfg_wdata_i <= val[k];
      @(posedge clk_i);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count, input bit quiet_tail);
    for (int unsigned i = 0; i < count; i++) begin
      if (!(quiet_tail && i > count / 2) && $urandom_range(0, 3) == 0) begin
        pause($urandom_range(1, 3));
      end
      send_item(random_particle());
      if (i == count / 2) drain_pipeline();
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(particle(100*One, 100*One, 99*One, 101*One, 0, 10*One, 5*One, 52429, 1, 0));
    send_item(particle(2*One, 50*One, 4*One, 50*One, 0, 0, 5*One, 65536, 1, 0));
    send_item(particle(2*One, 50*One, 4*One, 50*One, -One, 0, 5*One, 0, 1, 0));
    send_item(particle(798*One, 50*One, 796*One, 50*One, One, 0, 5*One, 131071, 1, 0));
    send_item(particle(50*One, One, 50*One, 3*One, 0, -One, 5*One, 32768, 1, 0));
    send_item(particle(50*One, 599*One, 50*One, 590*One, 0, 9*One, 5*One, 65536, 1, 0));
    // edge over the wall but moving away: velocity kept
    send_item(particle(One, 599*One, 0, 600*One, 0, 0, 5*One, 40000, 1, 0));
    // pinned, still clamped
    send_item(particle(One, 598*One, 3*One, 590*One, 7*One, 7*One, 5*One, 65536, 0, 0));
    send_item(particle(300*One, 200*One, 310*One, 190*One, One, One, 5*One, 65536, 0, 0));
    // wider than the arena
    send_item(particle(400*One, 300*One, 401*One, 299*One, 0, 0, 500*One, 65536, 1, 0));
    send_item(particle(64'sd2147483647, 64'sd2147483647, -64'sd2147483648,
                       -64'sd2147483648, 0, 0, 0, 131071, 1, 0));
    send_item(particle(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647,
                       64'sd2147483647, 0, 0, 0, 131071, 1, 1));
    send_item(particle(400*One, 300*One, 400*One, 300*One, 64'sd2147483647,
                       -64'sd2147483648, One, 65536, 1, 0));
    send_item(particle(400*One, 300*One, 400*One, 300*One, -64'sd2147483648,
                       64'sd2147483647, One, 65536, 1, 0));
    send_item(particle(400*One, 300*One, 390*One, 310*One, 0, 0, 64'sd2147483647, 131071,
                       1, 0));
    send_item(particle(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send_item(particle(-1, -1, -1, -1, -1, -1, 64'sd2147483647, 131071, 1, 1));
    send_item(particle(3*One, 597*One, 6*One, 594*One, 0, 0, 4*One, 49152, 1, 1));
    send_item(particle(799*One, 2*One, 795*One, 6*One, 0, 0, 4*One, 16384, 0, 1));
    drain_pipeline();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(32'h0004_3000, 32'd60000, 32'd13107200, 32'd9830400);
        1: set_config(32'hFFFF_FFFF, 32'h0001_FFFF, 32'd0, 32'd0);
        2: set_config(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        3: set_config($urandom, $urandom, $urandom, $urandom);
        default: set_config(32'h0100_0000, 32'd65536, 32'd655360, 32'd1);
      endcase
      run_random(290, ph == 4);
      drain_pipeline();
    end

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
